FILE: rtl/core/dda_pkg.sv
// ----------------------------------------------------------------------------
// Degree-day accumulate package
// Shared widths, payload types, curve table and month lengths.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int TEMP_W        = 16;
  localparam int DD_W          = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int INC_W         = 30;
  localparam int D_W           = 22;
  localparam int S_W           = 20;
  localparam int SS_W          = 2 * S_W;
  localparam int E_W           = 41;
  localparam int DEN_W         = E_W + 1;
  localparam int A_W           = 21;
  localparam int K_W           = 5;
  localparam int R30_W         = 30;
  localparam int TERM_W        = 31;
  localparam int SUM_W         = 32;
  localparam int DAYS_W        = 21;
  localparam int Q_W           = S_W;
  localparam int TAYLOR_N      = 12;
  localparam int LN2_Q16       = 45426;
  localparam int LN2_RECIP     = 94548;
  localparam int EXP_ARG_MAX   = 1048576;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MONTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TMISS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DMISS = 2'd3;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic signed [DD_W-1:0]   previous_dd;
    logic                     last_cell;
  } in_item_t;

  typedef struct packed {
    logic signed [DD_W-1:0] new_dd;
    logic                   is_missing;
    logic                   cell_last;
  } out_item_t;

  typedef struct packed {
    logic                   vld;
    logic                   miss;
    logic                   last;
    logic signed [DD_W-1:0] prev;
    logic                   fit;
    logic [INC_W-1:0]       lin_inc;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [S_W-1:0]     s;
    logic [SS_W-1:0]    ss;
    logic [K_W-1:0]     k;
    logic [R30_W-1:0]   r30;
    logic [SUM_W-1:0]   sum;
  } xc_t;

  typedef struct packed {
    side_t            side;
    logic [S_W-1:0]   s;
    logic [SS_W-1:0]  ss;
    logic [E_W-1:0]   e;
  } ex_t;

  typedef struct packed {
    logic               below;
    logic signed [23:0] degree;
    logic signed [23:0] lo;
    logic signed [23:0] hi;
    logic [15:0]        shape;
    logic [19:0]        pw;
    logic [15:0]        rate;
    logic signed [23:0] anchor;
  } curve_t;

  localparam curve_t CURVES [4] = '{
    '{1'b1, 24'sd0,       -24'sd772663,  24'sd504112,  16'd44683, 20'd240625, 16'd10585,
      24'sd504112},
    '{1'b0, 24'sd327680,  -24'sd1446051, 24'sd739659,  16'd17137, 20'd848288, 16'd23043,
      -24'sd1446051},
    '{1'b1, 24'sd1179648, 24'sd729938,   24'sd1689534, 16'd38898, 20'd297951, 16'd16592,
      24'sd1689534},
    '{1'b0, 24'sd1179648, 24'sd486446,   24'sd1515276, 16'd29384, 20'd404801, 16'd21829,
      24'sd486446}
  };

  function automatic logic [DAYS_W-1:0] days_q16(input logic [3:0] m);
    logic [DAYS_W-1:0] d;
    case (m)
      4'd1:                      d = 21'd1850890;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 21'd1966080;
      default:                   d = 21'd2031616;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/dda_front.sv
// ----------------------------------------------------------------------------
// Degree-day front end
// Input decode, curve products and range reduction of the exp argument.
// ----------------------------------------------------------------------------
module dda_front import dda_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  in_item_t                 in_item,
  input  logic [1:0]               mode,
  input  logic signed [TEMP_W-1:0] tmiss,
  input  logic signed [DD_W-1:0]   dmiss,
  output xc_t                      xc_o
);

  curve_t c;
  assign c = CURVES[mode];

  side_t              s1_side_r, s1_side_nxt;
  logic [D_W-1:0]     s1_d_r, s1_d_nxt;
  logic signed [33:0] t_w, lo_w, hi_w, deg_w, anc_w, d_w, lin_w;

  always_comb begin
    t_w   = 34'(in_item.temperature) <<< (16 - FRAC_BITS);
    lo_w  = 34'(c.lo);
    hi_w  = 34'(c.hi);
    deg_w = 34'(c.degree);
    anc_w = 34'(c.anchor);
    s1_side_nxt.vld  = in_vld;
    s1_side_nxt.miss = (in_item.temperature == tmiss) || (in_item.previous_dd == dmiss);
    s1_side_nxt.last = in_item.last_cell;
    s1_side_nxt.prev = in_item.previous_dd;
    s1_side_nxt.fit  = (t_w >= lo_w) && (t_w < hi_w);
    d_w = c.below ? (anc_w - t_w) : (t_w - anc_w);
    if (s1_side_nxt.fit && d_w > 34'sd0) begin
      s1_d_nxt = d_w[D_W-1:0];
    end else begin
      s1_d_nxt = '0;
    end
    if (c.below && t_w < lo_w) begin
      lin_w = deg_w - t_w;
    end else if (!c.below && t_w >= hi_w) begin
      lin_w = t_w - deg_w;
    end else begin
      lin_w = '0;
    end
    if (lin_w < 34'sd0) begin
      s1_side_nxt.lin_inc = '0;
    end else begin
      s1_side_nxt.lin_inc = lin_w[INC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.vld <= 1'b0;
    end else if (en) begin
      s1_side_r <= s1_side_nxt;
      s1_d_r    <= s1_d_nxt;
    end
  end

  side_t          s2_side_r;
  logic [S_W-1:0] s2_s_r, s2_s_nxt;
  logic [D_W-1:0] s2_dr_r, s2_dr_nxt;
  logic [37:0]    sp, rp;

  always_comb begin
    sp = 38'(s1_d_r) * 38'(c.shape);
    rp = 38'(s1_d_r) * 38'(c.rate);
    s2_s_nxt  = sp[16 +: S_W];
    s2_dr_nxt = rp[16 +: D_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r.vld <= 1'b0;
    end else if (en) begin
      s2_side_r <= s1_side_r;
      s2_s_r    <= s2_s_nxt;
      s2_dr_r   <= s2_dr_nxt;
    end
  end

  side_t              s3_side_r;
  logic [S_W-1:0]     s3_s_r;
  logic [SS_W-1:0]    s3_ss_r, s3_ss_nxt;
  logic [A_W-1:0]     s3_a_r, s3_a_nxt;
  logic [37:0]        s3_p_r, s3_p_nxt;
  logic signed [23:0] a_w;

  always_comb begin
    a_w = signed'(24'(c.pw)) - signed'(24'(s2_dr_r));
    if (a_w < 24'sd0) begin
      s3_a_nxt = '0;
    end else if (a_w > signed'(24'(EXP_ARG_MAX))) begin
      s3_a_nxt = A_W'(EXP_ARG_MAX);
    end else begin
      s3_a_nxt = a_w[A_W-1:0];
    end
    s3_p_nxt  = 38'(s3_a_nxt) * 38'(LN2_RECIP);
    s3_ss_nxt = SS_W'(s2_s_r) * SS_W'(s2_s_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_side_r.vld <= 1'b0;
    end else if (en) begin
      s3_side_r <= s2_side_r;
      s3_s_r    <= s2_s_r;
      s3_ss_r   <= s3_ss_nxt;
      s3_a_r    <= s3_a_nxt;
      s3_p_r    <= s3_p_nxt;
    end
  end

  xc_t         xc_r, xc_nxt;
  logic [5:0]  q0;
  logic [21:0] qk, rem;

  always_comb begin
    q0  = s3_p_r[32 +: 6];
    qk  = 22'(q0) * 22'(LN2_Q16);
    rem = 22'(s3_a_r) - qk;
    xc_nxt.side = s3_side_r;
    xc_nxt.s    = s3_s_r;
    xc_nxt.ss   = s3_ss_r;
    xc_nxt.sum  = SUM_W'(1) << 30;
    if (rem >= 22'(LN2_Q16)) begin
      xc_nxt.k   = K_W'(q0 + 6'd1);
      xc_nxt.r30 = {16'(rem - 22'(LN2_Q16)), 14'b0};
    end else begin
      xc_nxt.k   = K_W'(q0);
      xc_nxt.r30 = {rem[15:0], 14'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xc_r.side.vld <= 1'b0;
    end else if (en) begin
      xc_r <= xc_nxt;
    end
  end

  assign xc_o = xc_r;

endmodule

FILE: rtl/core/dda_exp.sv
// ----------------------------------------------------------------------------
// Degree-day exponential
// Pipelined Taylor series of the reduced argument and scaling by 2^k.
// ----------------------------------------------------------------------------
module dda_exp import dda_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  xc_t  xc_i,
  output ex_t  ex_o
);

  xc_t               tk_xc   [TAYLOR_N+1];
  logic [TERM_W-1:0] tk_term [TAYLOR_N+1];

  assign tk_xc[0]   = xc_i;
  assign tk_term[0] = TERM_W'(1) << 30;

  for (genvar g = 0; g < TAYLOR_N; g++) begin : g_term
    localparam int DIV = g + 1;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DIV);

    xc_t               a_xc_r, b_xc_r, c_xc_r, c_xc_nxt;
    logic [TERM_W-1:0] a_x_r, b_x_r, c_term_r, c_term_nxt;
    logic [60:0]       a_prod;
    logic [63:0]       b_m_r, b_m_nxt;
    logic [TERM_W-1:0] q0;
    logic [TERM_W+3:0] rem;

    assign a_prod  = 61'(tk_term[g]) * 61'(tk_xc[g].r30);
    assign b_m_nxt = 64'(a_x_r) * 64'(RECIP);

    always_comb begin
      q0  = b_m_r[32 +: TERM_W];
      rem = (TERM_W+4)'(b_x_r) - (TERM_W+4)'(q0) * (TERM_W+4)'(DIV);
      c_term_nxt = (rem >= (TERM_W+4)'(DIV)) ? q0 + TERM_W'(1) : q0;
      c_xc_nxt     = b_xc_r;
      c_xc_nxt.sum = b_xc_r.sum + SUM_W'(c_term_nxt);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_xc_r.side.vld <= 1'b0;
        b_xc_r.side.vld <= 1'b0;
        c_xc_r.side.vld <= 1'b0;
      end else if (en) begin
        a_xc_r   <= tk_xc[g];
        a_x_r    <= a_prod[30 +: TERM_W];
        b_xc_r   <= a_xc_r;
        b_x_r    <= a_x_r;
        b_m_r    <= b_m_nxt;
        c_xc_r   <= c_xc_nxt;
        c_term_r <= c_term_nxt;
      end
    end

    assign tk_xc[g+1]   = c_xc_r;
    assign tk_term[g+1] = c_term_r;
  end

  ex_t         ex_r, ex_nxt;
  logic [54:0] e_full;

  always_comb begin
    e_full      = 55'(tk_xc[TAYLOR_N].sum) << tk_xc[TAYLOR_N].k;
    ex_nxt.side = tk_xc[TAYLOR_N].side;
    ex_nxt.s    = tk_xc[TAYLOR_N].s;
    ex_nxt.ss   = tk_xc[TAYLOR_N].ss;
    ex_nxt.e    = e_full[14 +: E_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_r.side.vld <= 1'b0;
    end else if (en) begin
      ex_r <= ex_nxt;
    end
  end

  assign ex_o = ex_r;

endmodule

FILE: rtl/core/dda_div.sv
// ----------------------------------------------------------------------------
// Degree-day divider
// Pipelined restoring division of s*s by s + exp, one quotient bit a stage.
// ----------------------------------------------------------------------------
module dda_div import dda_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  ex_t            ex_i,
  output side_t          side_o,
  output logic [Q_W-1:0] q_o
);

  localparam int CMP_W = DEN_W + Q_W;

  side_t            dv_side [Q_W+1];
  logic [DEN_W-1:0] dv_den  [Q_W+1];
  logic [SS_W-1:0]  dv_rem  [Q_W+1];
  logic [Q_W-1:0]   dv_q    [Q_W+1];

  side_t            d0_side_r;
  logic [DEN_W-1:0] d0_den_r;
  logic [SS_W-1:0]  d0_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_side_r.vld <= 1'b0;
    end else if (en) begin
      d0_side_r <= ex_i.side;
      d0_den_r  <= DEN_W'(ex_i.s) + DEN_W'(ex_i.e);
      d0_rem_r  <= ex_i.ss;
    end
  end

  assign dv_side[0] = d0_side_r;
  assign dv_den[0]  = d0_den_r;
  assign dv_rem[0]  = d0_rem_r;
  assign dv_q[0]    = '0;

  for (genvar g = 0; g < Q_W; g++) begin : g_bit
    localparam int B = Q_W - 1 - g;

    side_t            side_r;
    logic [DEN_W-1:0] den_r;
    logic [SS_W-1:0]  rem_r, rem_nxt;
    logic [Q_W-1:0]   q_r, q_nxt;
    logic [CMP_W-1:0] den_sh;

    always_comb begin
      den_sh  = CMP_W'(dv_den[g]) << B;
      rem_nxt = dv_rem[g];
      q_nxt   = dv_q[g];
      if (CMP_W'(dv_rem[g]) >= den_sh) begin
        rem_nxt  = SS_W'(CMP_W'(dv_rem[g]) - den_sh);
        q_nxt[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r.vld <= 1'b0;
      end else if (en) begin
        side_r <= dv_side[g];
        den_r  <= dv_den[g];
        rem_r  <= rem_nxt;
        q_r    <= q_nxt;
      end
    end

    assign dv_side[g+1] = side_r;
    assign dv_den[g+1]  = den_r;
    assign dv_rem[g+1]  = rem_r;
    assign dv_q[g+1]    = q_r;
  end

  assign side_o = dv_side[Q_W];
  assign q_o    = dv_q[Q_W];

endmodule

FILE: rtl/core/dda_final.sv
// ----------------------------------------------------------------------------
// Degree-day final stages
// Month scaling, saturating accumulate, missing-code handling, output register.
// ----------------------------------------------------------------------------
module dda_final import dda_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  side_t                  side_i,
  input  logic [Q_W-1:0]         q_i,
  input  logic [3:0]             month,
  input  logic signed [DD_W-1:0] dmiss,
  output logic                   out_vld,
  output out_item_t              out_item
);

  localparam int P_W = INC_W + DAYS_W;

  side_t          f1_side_r;
  logic [P_W-1:0] f1_prod_r, f1_prod_nxt;
  logic [INC_W-1:0] inc;

  always_comb begin
    inc = side_i.fit ? INC_W'(q_i) : side_i.lin_inc;
    f1_prod_nxt = P_W'(inc) * P_W'(days_q16(month));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_side_r.vld <= 1'b0;
    end else if (en) begin
      f1_side_r <= side_i;
      f1_prod_r <= f1_prod_nxt;
    end
  end

  logic                   out_vld_r;
  out_item_t              out_item_r, out_item_nxt;
  logic [P_W-1:0]         sh;
  logic signed [P_W+1:0]  sum_w;
  logic signed [DD_W-1:0] sat;

  always_comb begin
    sh    = f1_prod_r >> (32 - FRAC_BITS);
    sum_w = (P_W+2)'(f1_side_r.prev) + signed'({2'b00, sh});
    if (sum_w > signed'((P_W+2)'(32'h7FFFFFFF))) begin
      sat = 32'sh7FFFFFFF;
    end else if (sum_w < -signed'((P_W+2)'(33'h080000000))) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum_w[DD_W-1:0];
    end
    out_item_nxt.new_dd     = f1_side_r.miss ? dmiss : sat;
    out_item_nxt.is_missing = (out_item_nxt.new_dd == dmiss);
    out_item_nxt.cell_last  = f1_side_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r  <= f1_side_r.vld;
      out_item_r <= out_item_nxt;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_item_r;

endmodule

FILE: rtl/core/degree_days_accumulate_top.sv
// ----------------------------------------------------------------------------
// Degree-day accumulate top level
// Updates a running degree-day total from one cell's monthly mean temperature.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_item_t (temperature, previous_dd, last_cell)
// out_      output     out_valid/out_stall out_item_t (new_dd, is_missing, cell_last)
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transaction is accepted every cycle while the output is not stalled.
// The pipeline includes the 36-stage Taylor series and the 21-stage divider.
// A stalled output freezes the whole pipeline, and in_stall follows it.
// Reset is synchronous, clears the valid bits and sets the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module degree_days_accumulate_top import dda_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [1:0]               mode_r;
  logic [3:0]               month_r;
  logic signed [TEMP_W-1:0] tmiss_r;
  logic signed [DD_W-1:0]   dmiss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 2'd0;
      month_r <= 4'd0;
      tmiss_r <= 16'sh8000;
      dmiss_r <= 32'sh80000000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:  mode_r  <= cfg_data[1:0];
        REG_MONTH: month_r <= cfg_data[3:0];
        REG_TMISS: tmiss_r <= cfg_data[TEMP_W-1:0];
        REG_DMISS: dmiss_r <= cfg_data[DD_W-1:0];
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  xc_t            xc;
  ex_t            ex;
  side_t          dv_side;
  logic [Q_W-1:0] dv_q;

  dda_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .in_item (in_item),
    .mode    (mode_r),
    .tmiss   (tmiss_r),
    .dmiss   (dmiss_r),
    .xc_o    (xc)
  );

  dda_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .xc_i  (xc),
    .ex_o  (ex)
  );

  dda_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ex_i   (ex),
    .side_o (dv_side),
    .q_o    (dv_q)
  );

  dda_final #(.FRAC_BITS(FRAC_BITS)) u_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .side_i   (dv_side),
    .q_i      (dv_q),
    .month    (month_r),
    .dmiss    (dmiss_r),
    .out_vld  (out_valid),
    .out_item (out_item)
  );

endmodule

FILE: rtl/core/dda_checker.sv
// ----------------------------------------------------------------------------
// Degree-day accumulate checker
// Port-level properties of the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module dda_checker import dda_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item,
  input logic      cfg_ready
);

  // A result is never presented in the cycle after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // The input side stalls only when the output is blocked.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output stall");

  // Configuration writes are always taken.
  assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind degree_days_accumulate_top dda_checker u_dda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item),
  .cfg_ready (cfg_ready)
);
